// ===== rtl/vosl_pkg.sv =====
// vosl_pkg: shared types and angle constants for the view offset slew limiter.
// Angles are signed fixed point with 10 fraction bits (1/1024 degree).
// No dependencies.
package vosl_pkg;

  localparam int ELAPSED_W = 10;
  localparam int ANG_W     = 20;

  typedef logic signed [ANG_W-1:0] ang_t;

  typedef struct packed {
    logic [18:0]        heading;
    logic signed [17:0] pitch;
    logic signed [18:0] roll;
  } vosl_axes_t;

  localparam ang_t DEG_HALF    = 20'sd512;
  localparam ang_t DEG_ONE     = 20'sd1024;
  localparam ang_t DEG_90      = 20'sd92160;
  localparam ang_t DEG_90_NEG  = -20'sd92160;
  localparam ang_t DEG_PCLAMP  = 20'sd92158;
  localparam ang_t DEG_PCL_NEG = -20'sd92158;
  localparam ang_t DEG_180     = 20'sd184320;
  localparam ang_t DEG_360     = 20'sd368640;

endpackage

// ===== rtl/vosl_step.sv =====
// vosl_step: one slew step for heading, pitch and roll toward their goals.
// Shared by every iteration of the sequencer in the top level.
// Depends on vosl_pkg.
module vosl_step
  import vosl_pkg::*;
(
  input  vosl_axes_t cur,
  input  vosl_axes_t goal,
  output vosl_axes_t nxt
);

  function automatic ang_t slew_lin(input ang_t c, input ang_t g);
    ang_t d;
    ang_t m;
    ang_t s;
    d = g - c;
    m = (d < 0) ? -d : d;
    if (m < DEG_ONE) begin
      s = g;
    end else begin
      s = (d > 0) ? c + DEG_ONE : c - DEG_ONE;
      if (s > DEG_90) begin
        s = DEG_90;
      end else if (s < DEG_90_NEG) begin
        s = DEG_90_NEG;
      end
    end
    return s;
  endfunction

  ang_t h_cur;
  ang_t h_goal;
  ang_t h_diff;
  ang_t h_mag;
  ang_t h_move;
  ang_t p_cur;
  ang_t p_goal;
  ang_t r_cur;
  ang_t r_goal;
  ang_t p_next;
  ang_t r_next;

  assign h_cur  = signed'({1'b0, cur.heading});
  assign h_goal = signed'({1'b0, goal.heading});
  assign p_cur  = signed'({{2{cur.pitch[17]}}, cur.pitch});
  assign p_goal = signed'({{2{goal.pitch[17]}}, goal.pitch});
  assign r_cur  = signed'({cur.roll[18], cur.roll});
  assign r_goal = signed'({goal.roll[18], goal.roll});

  always_comb begin
    h_diff = h_goal - h_cur;
    h_mag  = (h_diff < 0) ? -h_diff : h_diff;
    if (h_mag < DEG_ONE) begin
      h_move = h_goal;
    end else begin
      if (h_diff > 0) begin
        h_move = (h_mag < DEG_180) ? h_cur + DEG_HALF : h_cur - DEG_HALF;
      end else begin
        h_move = (h_mag < DEG_180) ? h_cur - DEG_HALF : h_cur + DEG_HALF;
      end
      if (h_move > DEG_360) begin
        h_move = h_move - DEG_360;
      end else if (h_move < 0) begin
        h_move = h_move + DEG_360;
      end
    end
  end

  assign p_next = slew_lin(p_cur, p_goal);
  assign r_next = slew_lin(r_cur, r_goal);

  assign nxt.heading = h_move[18:0];
  assign nxt.pitch   = p_next[17:0];
  assign nxt.roll    = r_next[18:0];

endmodule

// ===== rtl/view_offset_slew_limiter_unit.sv =====
// view_offset_slew_limiter_unit: top level, sequencer around one shared slew step unit.
// Depends on vosl_pkg and vosl_step.
//
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_stall  | elapsed_ms, goal_heading, goal_pitch, goal_roll
// out      | out_valid/out_stall| heading_now, pitch_now, roll_now
// cfg      | cfg_we             | cfg_wdata (heading_locked)
//
// An item passes through an accept state, a heading wrap state that adds or removes
// whole turns until the goal lies in 0..360 degrees, min(elapsed_ms, MAX_STEPS) slew
// steps in the step state, and an output load state.
// The slew step unit is the loop: it advances all three axes once per cycle.
// Reset (synchronous, rst_n low) clears all offsets and the heading lock.
// A new item is taken while a result still waits; the output loads once the
// previous result has been taken.
module view_offset_slew_limiter_unit
  import vosl_pkg::*;
#(
  parameter int MAX_STEPS = 1023
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_elapsed_ms,
  input  logic signed [20:0] in_goal_heading,
  input  logic signed [18:0] in_goal_pitch,
  input  logic signed [18:0] in_goal_roll,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [18:0]        out_heading_now,
  output logic signed [17:0] out_pitch_now,
  output logic signed [17:0] out_roll_now
);

  localparam int ELAPSED_MAX = (1 << ELAPSED_W) - 1;
  localparam logic [ELAPSED_W-1:0] STEP_CAP =
    ELAPSED_W'((MAX_STEPS > ELAPSED_MAX) ? ELAPSED_MAX : MAX_STEPS);
  localparam logic signed [21:0] GH_TURN = 22'sd368640;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRAP,
    ST_STEP,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   locked_r, locked_nxt;
  logic signed [21:0]     gh_r, gh_nxt;
  logic signed [17:0]     gp_r, gp_nxt;
  logic signed [18:0]     gr_r, gr_nxt;
  logic [ELAPSED_W-1:0]   cnt_r, cnt_nxt;
  vosl_axes_t             cur_r, cur_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [18:0]            out_h_r, out_h_nxt;
  logic signed [17:0]     out_p_r, out_p_nxt;
  logic signed [17:0]     out_rl_r, out_rl_nxt;

  vosl_axes_t goal;
  vosl_axes_t step_nxt;
  ang_t       gp_in;
  ang_t       gp_clamped;

  assign goal.heading = gh_r[18:0];
  assign goal.pitch   = gp_r;
  assign goal.roll    = gr_r;

  vosl_step u_step (
    .cur  (cur_r),
    .goal (goal),
    .nxt  (step_nxt)
  );

  assign gp_in = signed'({in_goal_pitch[18], in_goal_pitch});

  always_comb begin
    if (gp_in > DEG_PCLAMP) begin
      gp_clamped = DEG_PCLAMP;
    end else if (gp_in < DEG_PCL_NEG) begin
      gp_clamped = DEG_PCL_NEG;
    end else begin
      gp_clamped = gp_in;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    locked_nxt    = locked_r;
    gh_nxt        = gh_r;
    gp_nxt        = gp_r;
    gr_nxt        = gr_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_h_nxt     = out_h_r;
    out_p_nxt     = out_p_r;
    out_rl_nxt    = out_rl_r;

    if (cfg_we) begin
      locked_nxt = cfg_wdata;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          gh_nxt  = locked_r ? '0 : signed'({in_goal_heading[20], in_goal_heading});
          gp_nxt  = gp_clamped[17:0];
          gr_nxt  = in_goal_roll;
          cnt_nxt = (in_elapsed_ms > STEP_CAP) ? STEP_CAP : in_elapsed_ms;
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (gh_r < 0) begin
          gh_nxt = gh_r + GH_TURN;
        end else if (gh_r > GH_TURN) begin
          gh_nxt = gh_r - GH_TURN;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          cur_nxt = step_nxt;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_h_nxt     = cur_r.heading;
          out_p_nxt     = cur_r.pitch;
          out_rl_nxt    = cur_r.roll[17:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      locked_r    <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      locked_r    <= locked_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    gh_r     <= gh_nxt;
    gp_r     <= gp_nxt;
    gr_r     <= gr_nxt;
    cnt_r    <= cnt_nxt;
    out_h_r  <= out_h_nxt;
    out_p_r  <= out_p_nxt;
    out_rl_r <= out_rl_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_heading_now = out_h_r;
  assign out_pitch_now   = out_p_r;
  assign out_roll_now    = out_rl_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_WRAP))
    else $error("sequencer did not start after an accepted item");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.heading <= 19'd368640))
    else $error("heading offset left 0..360 degrees");

  a_goal_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (gh_r >= 0 && gh_r <= GH_TURN))
    else $error("goal heading not wrapped before slewing");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.pitch <= 18'sd92160 && cur_r.pitch >= -18'sd92160))
    else $error("pitch offset beyond 90 degrees");

endmodule
